@@ rtl/core/wall_column_texture_sampler_assert.svh @@
// Assertion macros for the checker file of the wall sampler.
`ifndef WALL_COLUMN_TEXTURE_SAMPLER_ASSERT_SVH
`define WALL_COLUMN_TEXTURE_SAMPLER_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define WCTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wall sampler: same-cycle check failed");

// Next-cycle implication, quiet while reset is asserted.
`define WCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wall sampler: next-cycle check failed");

`endif

@@ rtl/core/wcts_pkg.sv @@
`timescale 1ns / 1ps
package wcts_pkg;

	localparam int TEX_MAX_DEF   = 64;
	localparam int SCREEN_HEIGHT = 512;
	localparam int DIM_W         = 16;
	localparam int CFG_W         = 7;
	localparam int COLOR_W       = 24;
	localparam int ENTRY_W       = COLOR_W + 1;
	localparam int Y_W           = 18;
	localparam int IN_DATA_W     = 104;
	localparam int OUT_DATA_W    = 48;

	localparam logic [1:0] REG_TEX_WIDTH   = 2'd0;
	localparam logic [1:0] REG_TEX_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_TEX_PRESENT = 2'd2;

	localparam logic ACT_DRAW = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	localparam logic [COLOR_W-1:0] FACE_DEFAULT [4] = '{
		24'd15594228, 24'd8419710, 24'd9279918, 24'd2829634
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_READ,
		ST_FIN
	} wcts_state_t;

endpackage

@@ rtl/core/wall_column_texture_sampler.sv @@
`timescale 1ns / 1ps
// Wall column texture sampler: colours one raycaster wall pixel per draw word.
// Input channel s_axis: tuser selects the action (0 draw, 1 load texel);
// a load word writes one texel of one face into the texture RAM and gives
// no result, a draw word gives one word on m_axis with x, y and colour.
// Draws with row_index not below wall_height are dropped without a result.
// Configuration: cfg_we/cfg_index/cfg_wdata write texture width, height and
// the per-face texture-present mask; write them only while the block idles.
// Timing: a load leaves the block ready for the next word. A draw holds
// s_axis_tready low through its steps: one multiply step, the restoring
// divider at one quotient bit per cycle plus a step to see it finish, one
// RAM read step with registered read data and a final step to form the
// colour; the divider sets the length of a draw. The pixel word turns
// valid once the final step hands it to the output register.
// The result sits in an output register, so the next word is accepted while
// it waits; if m_axis_tready stays low, the following draw holds in its
// final step until the register frees.
// Reset clears the carried colour to zero, width and height to 64 and the
// present mask to zero; texture RAM contents stay undefined until loaded.
module wall_column_texture_sampler #(
	parameter int TEX_MAX = wcts_pkg::TEX_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input words.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata from bit 0: face[1:0], column[11:2], row_index[27:12],
	// wall_height[43:28], hit_fraction[59:44], load_row[65:60],
	// load_col[71:66], load_color[95:72], load_transparent[96], zero pad
	input  logic [wcts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: action[0]
	input  logic                            s_axis_tuser,
	// Result words.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata from bit 0: pixel_x[9:0], pixel_y[18:10], pixel_color[42:19], zero pad
	output logic [wcts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [wcts_pkg::CFG_W-1:0]      cfg_wdata
);

	localparam int QW    = $clog2(TEX_MAX);
	localparam int DEPTH = 4 * TEX_MAX * TEX_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = wcts_pkg::DIM_W + QW;
	localparam int FW    = wcts_pkg::DIM_W + QW;

	// Unpack the input word.
	logic [1:0]                       in_face;
	logic [9:0]                       in_column;
	logic [wcts_pkg::DIM_W-1:0]       in_row;
	logic [wcts_pkg::DIM_W-1:0]       in_height;
	logic [wcts_pkg::DIM_W-1:0]       in_frac;
	logic [5:0]                       in_load_row;
	logic [5:0]                       in_load_col;
	logic [wcts_pkg::COLOR_W-1:0]     in_load_color;
	logic                             in_load_transp;

	assign in_face        = s_axis_tdata[1:0];
	assign in_column      = s_axis_tdata[11:2];
	assign in_row         = s_axis_tdata[27:12];
	assign in_height      = s_axis_tdata[43:28];
	assign in_frac        = s_axis_tdata[59:44];
	assign in_load_row    = s_axis_tdata[65:60];
	assign in_load_col    = s_axis_tdata[71:66];
	assign in_load_color  = s_axis_tdata[95:72];
	assign in_load_transp = s_axis_tdata[96];

	// Texel address: (face * TEX_MAX + row) * TEX_MAX + col.
	function automatic logic [AW-1:0] tex_addr(input logic [1:0] f, input logic [7:0] r,
			input logic [7:0] c);
		tex_addr = (AW'(f) * AW'(TEX_MAX) + AW'(r)) * AW'(TEX_MAX) + AW'(c);
	endfunction

	// Size register to size-1, with 0 read as 1 and oversize read as TEX_MAX.
	function automatic logic [QW-1:0] size_m1(input logic [wcts_pkg::CFG_W-1:0] v);
		if (v == '0) begin
			size_m1 = '0;
		end else if (32'(v) > TEX_MAX) begin
			size_m1 = QW'(TEX_MAX - 1);
		end else begin
			size_m1 = QW'(v - wcts_pkg::CFG_W'(1));
		end
	endfunction

	// Configuration registers.
	logic [wcts_pkg::CFG_W-1:0] tex_width_q;
	logic [wcts_pkg::CFG_W-1:0] tex_height_q;
	logic [3:0]                 tex_present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q   <= wcts_pkg::CFG_W'(64);
			tex_height_q  <= wcts_pkg::CFG_W'(64);
			tex_present_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wcts_pkg::REG_TEX_WIDTH:   tex_width_q   <= cfg_wdata;
				wcts_pkg::REG_TEX_HEIGHT:  tex_height_q  <= cfg_wdata;
				wcts_pkg::REG_TEX_PRESENT: tex_present_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	wcts_pkg::wcts_state_t state_q, state_n;
	logic in_accept;
	logic draw_ok;
	logic load_ok;
	logic div_start;
	logic div_done;
	logic rd_en;
	logic fin_take;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign draw_ok   = (s_axis_tuser == wcts_pkg::ACT_DRAW) && (in_row < in_height);
	assign load_ok   = (s_axis_tuser == wcts_pkg::ACT_LOAD)
	                   && (9'(in_load_row) < 9'(TEX_MAX)) && (9'(in_load_col) < 9'(TEX_MAX));

	always_comb begin
		state_n = state_q;
		case (state_q)
			wcts_pkg::ST_IDLE: begin
				if (in_accept && draw_ok) begin
					state_n = wcts_pkg::ST_MUL;
				end
			end
			wcts_pkg::ST_MUL:  state_n = wcts_pkg::ST_DIV;
			wcts_pkg::ST_DIV: begin
				if (div_done) begin
					state_n = wcts_pkg::ST_READ;
				end
			end
			wcts_pkg::ST_READ: state_n = wcts_pkg::ST_FIN;
			wcts_pkg::ST_FIN: begin
				if (fin_take) begin
					state_n = wcts_pkg::ST_IDLE;
				end
			end
			default:           state_n = wcts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		rd_en         = 1'b0;
		fin_take      = 1'b0;
		case (state_q)
			wcts_pkg::ST_IDLE: s_axis_tready = 1'b1;
			wcts_pkg::ST_MUL:  div_start     = 1'b1;
			wcts_pkg::ST_READ: rd_en         = 1'b1;
			wcts_pkg::ST_FIN:  fin_take      = !m_axis_tvalid || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcts_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Hold the draw fields for the length of the draw.
	logic [1:0]                 face_q;
	logic [9:0]                 column_q;
	logic [wcts_pkg::DIM_W-1:0] row_q;
	logic [wcts_pkg::DIM_W-1:0] height_q;
	logic [wcts_pkg::DIM_W-1:0] frac_q;
	logic [QW-1:0]              tcol_q;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			face_q   <= in_face;
			column_q <= in_column;
			row_q    <= in_row;
			height_q <= in_height;
			frac_q   <= in_frac;
		end
	end

	// Multiply step: texel column now, texel row numerator into the divider.
	logic [PW-1:0] row_prod;
	logic [FW-1:0] frac_prod;

	assign row_prod  = PW'(row_q) * PW'(size_m1(tex_height_q));
	assign frac_prod = FW'(frac_q) * FW'(size_m1(tex_width_q));

	always_ff @(posedge clk) begin
		if (div_start) begin
			tcol_q <= frac_prod[FW-1:wcts_pkg::DIM_W];
		end
	end

	logic [QW-1:0] trow;

	wcts_div #(
		.QUOT_W(QW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(row_prod),
		.divisor (height_q),
		.done    (div_done),
		.quotient(trow)
	);

	// Texture RAM: loads write on acceptance, draws read after the divide.
	logic [wcts_pkg::ENTRY_W-1:0] rd_entry;

	wcts_ram #(
		.WIDTH(wcts_pkg::ENTRY_W),
		.DEPTH(DEPTH)
	) u_tex_ram (
		.clk    (clk),
		.wr_en  (in_accept && load_ok),
		.wr_addr(tex_addr(in_face, 8'(in_load_row), 8'(in_load_col))),
		.wr_data({in_load_transp, in_load_color}),
		.rd_en  (rd_en),
		.rd_addr(tex_addr(face_q, 8'(trow), 8'(tcol_q))),
		.rd_data(rd_entry)
	);

	// Colour: restart from the face default on row 0, take opaque texels only.
	logic [wcts_pkg::COLOR_W-1:0] carried_q;
	logic [wcts_pkg::COLOR_W-1:0] base_color;
	logic [wcts_pkg::COLOR_W-1:0] new_color;

	always_comb begin
		base_color = (row_q == '0) ? wcts_pkg::FACE_DEFAULT[face_q] : carried_q;
		if (tex_present_q[face_q] && !rd_entry[wcts_pkg::COLOR_W]) begin
			new_color = rd_entry[wcts_pkg::COLOR_W-1:0];
		end else begin
			new_color = base_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carried_q <= '0;
		end else if (fin_take) begin
			carried_q <= new_color;
		end
	end

	// Screen row: centre the slice, force off-screen rows to the last row.
	logic [wcts_pkg::Y_W-1:0] y_full;
	logic [8:0]               pixel_y;

	always_comb begin
		y_full = wcts_pkg::Y_W'(row_q) + wcts_pkg::Y_W'(wcts_pkg::SCREEN_HEIGHT / 2)
		         - wcts_pkg::Y_W'(height_q[wcts_pkg::DIM_W-1:1]);
		if (y_full[wcts_pkg::Y_W-1]
		    || (y_full >= wcts_pkg::Y_W'(wcts_pkg::SCREEN_HEIGHT))) begin
			pixel_y = 9'(wcts_pkg::SCREEN_HEIGHT - 1);
		end else begin
			pixel_y = y_full[8:0];
		end
	end

	// Output register.
	logic                              out_valid_q;
	logic [wcts_pkg::OUT_DATA_W-1:0]   out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_take) begin
			out_data_q <= {5'b0, new_color, pixel_y, column_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/core/wcts_ram.sv @@
`timescale 1ns / 1ps
module wcts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/wcts_div.sv @@
`timescale 1ns / 1ps
module wcts_div #(
	parameter int QUOT_W = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [wcts_pkg::DIM_W+QUOT_W-1:0] dividend,
	input  logic [wcts_pkg::DIM_W-1:0]        divisor,
	output logic                              done,
	output logic [QUOT_W-1:0]                 quotient
);

	localparam int CNT_W = $clog2(QUOT_W + 1);

	// Quotient is known to fit QUOT_W bits, so the upper dividend bits
	// already stand below the divisor and seed the remainder.
	logic [CNT_W-1:0]                cnt_q;
	logic [wcts_pkg::DIM_W-1:0]      rem_q;
	logic [QUOT_W-1:0]               shift_q;
	logic [wcts_pkg::DIM_W:0]        rem_wide;
	logic                            ge;
	logic [wcts_pkg::DIM_W-1:0]      rem_n;
	logic [QUOT_W-1:0]               shift_n;

	always_comb begin
		rem_wide = {rem_q, shift_q[QUOT_W-1]};
		ge       = rem_wide >= {1'b0, divisor};
		rem_n    = ge ? wcts_pkg::DIM_W'(rem_wide - {1'b0, divisor})
		              : wcts_pkg::DIM_W'(rem_wide);
		shift_n    = shift_q << 1;
		shift_n[0] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUOT_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= dividend[wcts_pkg::DIM_W+QUOT_W-1:QUOT_W];
			shift_q <= dividend[QUOT_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q   <= rem_n;
			shift_q <= shift_n;
		end
	end

	assign done     = (cnt_q == '0) && !start;
	assign quotient = shift_q;

endmodule

@@ rtl/core/wcts_chk.sv @@
`timescale 1ns / 1ps
`include "wall_column_texture_sampler_assert.svh"
module wcts_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [wcts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                            s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [wcts_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// A texel load completes in its own cycle.
	`WCTS_ASSERT_NEXT(a_load_one_cycle, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, s_axis_tready)

	// A draw inside the slice occupies the block.
	`WCTS_ASSERT_NEXT(a_draw_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && !s_axis_tuser && (s_axis_tdata[27:12] < s_axis_tdata[43:28]), !s_axis_tready)

	// A new result only ever ends a busy draw.
	`WCTS_ASSERT_NOW(a_result_after_draw, clk, arst_n, $rose(m_axis_tvalid), !$past(s_axis_tready))

	// Hold a stalled result word.
	`WCTS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind wall_column_texture_sampler wcts_chk u_wcts_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Wall column texture sampler bench: stream loads and draws in, check pixels out.
module tb_top;
	import wcts_pkg::*;

	localparam int TEX         = TEX_MAX_DEF;
	localparam int TEXELS      = 4 * TEX * TEX;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 210;
	// Give the block ample room after the last word.
	localparam int SETTLE      = 24;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 600000;

	// Register settings per phase; out-of-range sizes (0, 127) exercise the clamp.
	localparam logic [CFG_W-1:0] PHASE_W [PHASES] = '{64, 1, 0, 127, 8, 3, 64, 2};
	localparam logic [CFG_W-1:0] PHASE_H [PHASES] = '{64, 1, 127, 0, 8, 5, 1, 33};
	localparam logic [3:0]       PHASE_P [PHASES] = '{15, 15, 10, 5, 15, 0, 9, 15};

	typedef enum logic [1:0] {
		FACE_N,
		FACE_S,
		FACE_E,
		FACE_W
	} face_e;

	// Input word, lowest field last: the packed layout of s_axis_tdata.
	typedef struct packed {
		logic [6:0]         pad;
		logic               transp;
		logic [COLOR_W-1:0] lcolour;
		logic [5:0]         lcol;
		logic [5:0]         lrow;
		logic [15:0]        frac;
		logic [15:0]        height;
		logic [15:0]        row;
		logic [9:0]         column;
		logic [1:0]         face;
	} wall_word_t;

	// Result word: pixel_x in the lowest bits, then pixel_y and the colour.
	typedef struct packed {
		logic [COLOR_W-1:0] colour;
		logic [8:0]         y;
		logic [9:0]         x;
	} pixel_t;

	// Shades pixels from accepted words and holds the pixels still owed by the block.
	class pixel_ledger;
		logic [ENTRY_W-1:0] texels [TEXELS];
		logic [COLOR_W-1:0] carried;
		logic [CFG_W-1:0]   tex_width;
		logic [CFG_W-1:0]   tex_height;
		logic [3:0]         present;
		pixel_t             owed [$];
		int unsigned        faults;

		function new();
			carried    = '0;
			tex_width  = CFG_W'(TEX);
			tex_height = CFG_W'(TEX);
			present    = '0;
			faults     = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_TEX_WIDTH: tex_width = v;
				REG_TEX_HEIGHT: tex_height = v;
				REG_TEX_PRESENT: present = v[3:0];
				default: ;
			endcase
		endfunction

		// Size in use: zero counts as one, anything above the store as the store.
		function int unsigned span(logic [CFG_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > TEX)
				return TEX;
			return v;
		endfunction

		// Store address a draw reads, or -1 when it reads nothing.
		function int texel_of(wall_word_t w);
			int unsigned rowv, hv, fv, trow, tcol;
			rowv = w.row;
			hv   = w.height;
			fv   = w.frac;
			if (hv == 0 || rowv >= hv || !present[w.face])
				return -1;
			trow = (rowv * (span(tex_height) - 1)) / hv;
			tcol = (fv * (span(tex_width) - 1)) >> 16;
			return (int'(w.face) * TEX + trow) * TEX + tcol;
		endfunction

		function void note_word(logic act, wall_word_t w);
			int a;
			int y;
			pixel_t p;
			if (act == ACT_LOAD) begin
				texels[(int'(w.face) * TEX + int'(w.lrow)) * TEX + int'(w.lcol)] =
					{w.transp, w.lcolour};
				return;
			end
			// Drop empty slices and rows past the slice: no pixel, no state change.
			if (w.height == 0 || w.row >= w.height)
				return;
			a = texel_of(w);
			if (w.row == 0)
				carried = FACE_DEFAULT[w.face];
			if (a >= 0 && !texels[a][COLOR_W])
				carried = texels[a][COLOR_W-1:0];
			y = int'(w.row) + SCREEN_HEIGHT / 2 - int'(w.height) / 2;
			if (y < 0 || y >= SCREEN_HEIGHT)
				y = SCREEN_HEIGHT - 1;
			p.x      = w.column;
			p.y      = 9'(y);
			p.colour = carried;
			owed.push_back(p);
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (owed.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected pixel: x=%0d y=%0d colour=%06h",
						got.x, got.y, got.colour);
				return;
			end
			want = owed.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.colour !== want.colour) begin
				faults++;
				if (faults <= 10)
					$display("pixel mismatch: expected x=%0d y=%0d colour=%06h, got x=%0d y=%0d colour=%06h",
						want.x, want.y, want.colour, got.x, got.y, got.colour);
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;

	pixel_ledger ledger;
	// Texels the stimulus has already sent; draws never read anything else.
	bit          loaded [TEXELS];
	bit          no_idle;
	bit          long_hold_req;
	int unsigned words_sent;
	int unsigned cycles = 0;

	wall_column_texture_sampler i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Abort a run that hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Watch both channels; check the result side first so a pixel is never
	// matched against a word accepted on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				ledger.check_pixel(m_axis_tdata[$bits(pixel_t)-1:0]);
			if (s_axis_tvalid && s_axis_tready)
				ledger.note_word(s_axis_tuser, s_axis_tdata);
		end
	end

	// Result side: stall at random before each pixel, and once hold off for a long
	// stretch so the output register fills and the input stalls.
	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (long_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end
			gap = no_idle ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// Fill every field with noise, padding cleared.
	function automatic wall_word_t scrambled_word();
		logic [127:0] bits;
		wall_word_t w;
		bits  = {$urandom, $urandom, $urandom, $urandom};
		w     = bits[IN_DATA_W-1:0];
		w.pad = '0;
		return w;
	endfunction

	// Draw word with noise in the load fields, which a draw ignores.
	function automatic wall_word_t make_draw(logic [1:0] face, logic [9:0] column,
			logic [15:0] row, logic [15:0] height, logic [15:0] frac);
		wall_word_t w;
		w        = scrambled_word();
		w.face   = face;
		w.column = column;
		w.row    = row;
		w.height = height;
		w.frac   = frac;
		return w;
	endfunction

	// Offer one word after a random gap and hold it until accepted.
	task automatic push_word(input logic act, input wall_word_t w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	task automatic put_texel(input int unsigned face, input int unsigned r,
			input int unsigned c, input logic [COLOR_W-1:0] colour, input logic transp);
		wall_word_t w;
		w         = scrambled_word();
		w.face    = 2'(face);
		w.lrow    = 6'(r);
		w.lcol    = 6'(c);
		w.lcolour = colour;
		w.transp  = transp;
		loaded[(face * TEX + r) * TEX + c] = 1'b1;
		push_word(ACT_LOAD, w);
	endtask

	// Send a draw, loading its texel first when that texel was never written.
	task automatic paint(input wall_word_t w);
		int a;
		a = ledger.texel_of(w);
		if (a >= 0 && !loaded[a])
			put_texel(a / (TEX * TEX), (a / TEX) % TEX, a % TEX, COLOR_W'($urandom),
				$urandom_range(0, 3) == 0);
		push_word(ACT_DRAW, w);
	endtask

	task automatic poke(input logic [1:0] idx, input logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		ledger.write_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
			input logic [3:0] pv);
		poke(REG_TEX_WIDTH, wv);
		poke(REG_TEX_HEIGHT, hv);
		poke(REG_TEX_PRESENT, CFG_W'(pv));
		cfg_we <= 1'b0;
	endtask

	// Drop valid, wait until every owed pixel is in, then let the block go idle.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int unsigned h, r, len, pick, start;
		logic [1:0]  face;
		logic [9:0]  col;
		logic [15:0] frac;
		bit          broken;
		wall_word_t  w;

		ledger        = new();
		words_sent    = 0;
		no_idle       = 1'b0;
		long_hold_req = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= ACT_DRAW;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_TEX_WIDTH;
		cfg_wdata     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, no face textured: load extremes, then default colours,
		// carried colour, screen-row clamps and dropped draws.
		put_texel(FACE_N, 0, 0, 24'h000000, 1'b0);
		put_texel(FACE_W, TEX - 1, TEX - 1, 24'hFFFFFF, 1'b1);
		paint(make_draw(FACE_N, 10'd0, 16'd0, 16'd1, 16'h0000));
		paint(make_draw(FACE_S, 10'd1023, 16'd0, 16'd2, 16'hFFFF));
		paint(make_draw(FACE_S, 10'd512, 16'd1, 16'd2, 16'h8000));
		paint(make_draw(FACE_E, 10'd3, 16'd0, 16'd60000, 16'h1234));
		paint(make_draw(FACE_W, 10'd4, 16'd0, 16'd1000, 16'h4321));
		paint(make_draw(FACE_W, 10'd4, 16'd999, 16'd1000, 16'h4321));
		paint(make_draw(FACE_N, 10'd5, 16'd0, 16'd0, 16'hAAAA));
		paint(make_draw(FACE_S, 10'd6, 16'd5, 16'd5, 16'h5555));
		paint(make_draw(FACE_E, 10'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		paint(make_draw(FACE_E, 10'd1023, 16'hFFFE, 16'hFFFF, 16'hFFFF));
		settle();

		// Every face textured: transparent texel, opaque black, last texel a draw can reach.
		write_regs(CFG_W'(TEX), CFG_W'(TEX), 4'hF);
		put_texel(FACE_S, 0, 0, 24'h00FF00, 1'b1);
		paint(make_draw(FACE_S, 10'd8, 16'd0, 16'd64, 16'h0000));
		paint(make_draw(FACE_N, 10'd9, 16'd0, 16'd1, 16'h0000));
		paint(make_draw(FACE_W, 10'd10, 16'hFFFE, 16'hFFFF, 16'hFFFF));
		paint(make_draw(FACE_E, 10'd11, 16'd3, 16'd8, 16'h8000));
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 5)
				write_regs(CFG_W'($urandom_range(1, TEX)), CFG_W'($urandom_range(1, TEX)),
					4'($urandom));
			else
				write_regs(PHASE_W[ph], PHASE_H[ph], PHASE_P[ph]);
			no_idle = ($urandom_range(0, 3) == 0);
			if (ph == 2)
				long_hold_req = 1'b1;
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					// One wall column: rows in ascending order, same face and hit.
					face   = 2'($urandom);
					col    = 10'($urandom);
					frac   = 16'($urandom);
					broken = ($urandom_range(0, 9) == 0);
					if ($urandom_range(0, 7) == 0) begin
						h = $urandom_range(25, 65535);
						r = $urandom_range(0, 1) ? 0 : $urandom_range(0, h - 1);
					end else begin
						h = $urandom_range(1, 24);
						r = 0;
					end
					len = $urandom_range(1, 24);
					// A broken column runs on past the slice.
					while (r < h + (broken ? 2 : 0) && len > 0) begin
						paint(make_draw(face, col, 16'(r), 16'(h), frac));
						r++;
						len--;
					end
				end else if (pick < 75) begin
					h = $urandom_range(1, 65535);
					paint(make_draw(2'($urandom), 10'($urandom), 16'($urandom_range(0, h - 1)),
						16'(h), 16'($urandom)));
				end else if (pick < 85) begin
					put_texel($urandom_range(0, 3), $urandom_range(0, TEX - 1),
						$urandom_range(0, TEX - 1), COLOR_W'($urandom),
						$urandom_range(0, 3) == 0);
				end else begin
					// Noise: mostly dropped draws, some with an empty slice.
					w = scrambled_word();
					if ($urandom_range(0, 3) == 0)
						w.height = '0;
					paint(w);
				end
			end
			settle();
		end

		if (ledger.faults == 0 && ledger.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
